// ----- rtl/rau_pkg.sv -----
// Package for the rational arithmetic unit: command codes, widths, back-end states, queue beat type.
// No dependencies.
package rau_pkg;
    localparam int NUM_W = 33;
    localparam int DEN_W = 32;
    localparam int MAG_W = 33;

    typedef enum logic [2:0] {
        t_cmd_add    = 3'd0,
        t_cmd_sub    = 3'd1,
        t_cmd_mul    = 3'd2,
        t_cmd_div    = 3'd3,
        t_cmd_reduce = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        t_be_idle,
        t_be_gcd,
        t_be_divn,
        t_be_divd,
        t_be_out
    } t_be_state;

    // One queued beat: raw numerator and denominator before reduction.
    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_raw;
endpackage

// ----- rtl/rau_front.sv -----
// Front end: accepts a command, forms raw numerator and denominator over two steps.
// Depends on rau_pkg.
module rau_front #(
    parameter int W = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_go,
    input  logic [2:0]         i_command,
    input  logic signed [W-1:0] i_a_num,
    input  logic signed [W-1:0] i_a_den,
    input  logic signed [W-1:0] i_b_num,
    input  logic signed [W-1:0] i_b_den,
    output logic               o_busy,
    output logic               o_valid,
    output rau_pkg::t_raw      o_raw,
    input  logic               i_take
);
    localparam int PW = 2 * W;

    logic [2:0]          r_cmd;
    logic signed [W-1:0] r_an, r_ad, r_bn;
    logic                r_eq, r_stage, r_full;
    logic signed [PW-1:0] r_p0, r_p1, r_p2;
    rau_pkg::t_raw       r_raw, n_raw;
    logic signed [PW:0]  s_n;

    assign o_busy  = r_stage | r_full;
    assign o_valid = r_full;
    assign o_raw   = r_raw;

    // Combine registered products into raw values
    always_comb begin
        n_raw = '0;
        s_n = '0;
        case (r_cmd)
            rau_pkg::t_cmd_add: begin
                if (r_eq) begin
                    s_n = (PW+1)'(r_an) + (PW+1)'(r_bn);
                    n_raw.den = rau_pkg::DEN_W'(r_ad);
                end else begin
                    s_n = (PW+1)'(r_p0) + (PW+1)'(r_p1);
                    n_raw.den = rau_pkg::DEN_W'(r_p2);
                end
            end
            rau_pkg::t_cmd_sub: begin
                if (r_eq) begin
                    s_n = (PW+1)'(r_an) - (PW+1)'(r_bn);
                    n_raw.den = rau_pkg::DEN_W'(r_ad);
                end else begin
                    s_n = (PW+1)'(r_p0) - (PW+1)'(r_p1);
                    n_raw.den = rau_pkg::DEN_W'(r_p2);
                end
            end
            rau_pkg::t_cmd_mul: begin
                s_n = (PW+1)'(r_p1);
                n_raw.den = rau_pkg::DEN_W'(r_p2);
            end
            rau_pkg::t_cmd_div: begin
                s_n = (PW+1)'(r_p0);
                n_raw.den = rau_pkg::DEN_W'(r_p1);
            end
            default: begin
                s_n = (PW+1)'(r_an);
                n_raw.den = rau_pkg::DEN_W'(r_ad);
            end
        endcase
        n_raw.num = rau_pkg::NUM_W'(s_n);
    end

    // Capture operands and products, then the raw beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= 1'b0;
            r_full  <= 1'b0;
        end else begin
            if (i_go && !o_busy) begin
                r_cmd <= i_command;
                r_an <= i_a_num; r_ad <= i_a_den;
                r_bn <= i_b_num;
                r_eq <= (i_a_den == i_b_den);
                // p0 = an*bd, p1 = bn*ad (or an*bn for mul, ad*bn for div), p2 = ad*bd
                r_p0 <= PW'(i_a_num) * PW'(i_b_den);
                case (i_command)
                    rau_pkg::t_cmd_mul: r_p1 <= PW'(i_a_num) * PW'(i_b_num);
                    rau_pkg::t_cmd_div: r_p1 <= PW'(i_a_den) * PW'(i_b_num);
                    default:            r_p1 <= PW'(i_b_num) * PW'(i_a_den);
                endcase
                r_p2 <= PW'(i_a_den) * PW'(i_b_den);
                r_stage <= 1'b1;
            end else if (r_stage) begin
                r_raw   <= n_raw;
                r_full  <= 1'b1;
                r_stage <= 1'b0;
            end else if (i_take) begin
                r_full <= 1'b0;
            end
        end
    end
endmodule

// ----- rtl/rau_queue.sv -----
// Two-entry queue between front and back ends.
// Depends on rau_pkg.
module rau_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rau_pkg::t_raw i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output rau_pkg::t_raw o_data
);
    rau_pkg::t_raw r_mem [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    // Advance pointers on push and pop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (i_push && !o_full) begin
                r_mem[r_wp] <= i_data;
                r_wp <= ~r_wp;
            end
            if (i_pop && o_valid) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'((i_push && !o_full) ? 1 : 0) - 2'((i_pop && o_valid) ? 1 : 0);
        end
    end
endmodule

// ----- rtl/rau_back.sv -----
// Back end: Euclid gcd by shift-subtract remainders, then two restoring divisions.
// Depends on rau_pkg.
module rau_back (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  rau_pkg::t_raw            i_raw,
    output logic                     o_pop,
    output logic                     o_strobe,
    output logic [rau_pkg::NUM_W-1:0] o_num,
    output logic [rau_pkg::DEN_W-1:0] o_den,
    output logic                     o_den_zero
);
    localparam int M = rau_pkg::MAG_W;
    localparam int CW = $clog2(M + 1);

    rau_pkg::t_be_state r_st, n_st;
    logic [M-1:0] r_x, r_y, r_rem, r_quo, r_g;
    logic [CW-1:0] r_cnt;
    logic          r_sn, r_sd, r_dz;
    logic [rau_pkg::NUM_W-1:0] r_num;
    logic [rau_pkg::DEN_W-1:0] r_den;
    logic [M-1:0] s_mn, s_md;
    logic [rau_pkg::DEN_W-1:0] s_dneg;
    logic [M:0]   s_trial;
    logic [M-1:0] s_src;

    assign s_mn   = i_raw.num[M-1] ? (~i_raw.num + 1'b1) : i_raw.num;
    assign s_dneg = ~i_raw.den + 1'b1;
    assign s_md   = i_raw.den[rau_pkg::DEN_W-1] ? M'(s_dneg) : M'(i_raw.den);
    // Division step: r_x is dividend being shifted out, divisor is r_y (gcd) or r_g
    assign s_src   = (r_st == rau_pkg::t_be_gcd) ? r_y : r_g;
    assign s_trial = {r_rem, r_x[M-1]} - {1'b0, s_src};

    assign o_pop      = (r_st == rau_pkg::t_be_idle) && i_valid;
    assign o_strobe   = (r_st == rau_pkg::t_be_out);
    assign o_num      = r_num;
    assign o_den      = r_den;
    assign o_den_zero = r_dz;

    always_comb begin
        n_st = r_st;
        case (r_st)
            rau_pkg::t_be_idle: if (i_valid) n_st = rau_pkg::t_be_gcd;
            rau_pkg::t_be_gcd:  if (r_y == '0) n_st = rau_pkg::t_be_divn;
            rau_pkg::t_be_divn: if (r_cnt == CW'(M)) n_st = rau_pkg::t_be_divd;
            rau_pkg::t_be_divd: if (r_cnt == CW'(M)) n_st = rau_pkg::t_be_out;
            rau_pkg::t_be_out:  n_st = rau_pkg::t_be_idle;
            default:            n_st = rau_pkg::t_be_idle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= rau_pkg::t_be_idle;
        else          r_st <= n_st;
    end

    // Datapath: one remainder bit per cycle in gcd/divide states while r_cnt < M
    always_ff @(posedge i_clk) begin
        case (r_st)
            rau_pkg::t_be_idle: begin
                r_sn  <= i_raw.num[M-1];
                r_sd  <= i_raw.den[rau_pkg::DEN_W-1];
                r_dz  <= (i_raw.den == '0);
                r_num <= s_mn;
                r_den <= rau_pkg::DEN_W'(s_md);
                r_cnt <= '0;
                r_rem <= '0;
                if (s_mn == '0 || s_md == '0) begin
                    r_x <= M'(1); r_y <= '0;
                end else begin
                    r_x <= s_mn; r_y <= s_md;
                end
            end
            rau_pkg::t_be_gcd: begin
                if (r_y == '0) begin
                    r_g <= r_x; r_cnt <= '0; r_rem <= '0;
                    r_x <= M'(r_num);
                end else if (r_cnt == CW'(M)) begin
                    r_x <= r_y; r_y <= r_rem; r_rem <= '0; r_cnt <= '0;
                end else begin
                    r_rem <= s_trial[M] ? {r_rem[M-2:0], r_x[M-1]} : s_trial[M-1:0];
                    r_x <= {r_x[M-2:0], 1'b0};
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            rau_pkg::t_be_divn, rau_pkg::t_be_divd: begin
                if (r_cnt == CW'(M)) begin
                    if (r_st == rau_pkg::t_be_divn) begin
                        r_num <= r_sn ? rau_pkg::NUM_W'(~r_quo + 1'b1) : rau_pkg::NUM_W'(r_quo);
                        r_x <= M'(r_den);
                    end else begin
                        r_den <= r_sd ? rau_pkg::DEN_W'(~r_quo + 1'b1) : rau_pkg::DEN_W'(r_quo);
                    end
                    r_cnt <= '0; r_rem <= '0;
                end else begin
                    r_rem <= s_trial[M] ? {r_rem[M-2:0], r_x[M-1]} : s_trial[M-1:0];
                    r_quo <= {r_quo[M-2:0], ~s_trial[M]};
                    r_x <= {r_x[M-2:0], 1'b0};
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            default: ;
        endcase
    end
endmodule

// ----- rtl/rational_arith_unit.sv -----
// Top level of the rational arithmetic unit: front end, queue, back end.
// Depends on rau_pkg, rau_front, rau_queue, rau_back.
//
// channel  | direction | handshake
// command  | in        | i_start / o_busy, taken when start high and busy low
// result   | out       | o_strobe, one cycle, no backpressure
//
// The front end registers the operands and products, then the raw beat, and
// the beat then enters the queue. The back end runs Euclid remainder steps,
// each a full shift-subtract pass (none when either raw value is zero, at most
// about 47), then two restoring divisions; the number of remainder steps sets
// how long a result takes after its command beat. Reset is synchronous, active
// low, and empties queue and sequencer. busy stays high while the front end
// holds a beat that the full queue cannot take.
module rational_arith_unit #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    output logic                       o_busy,
    input  logic [2:0]                 i_command,
    input  logic signed [OPERAND_WIDTH-1:0] i_a_num,
    input  logic signed [OPERAND_WIDTH-1:0] i_a_den,
    input  logic signed [OPERAND_WIDTH-1:0] i_b_num,
    input  logic signed [OPERAND_WIDTH-1:0] i_b_den,
    output logic                       o_strobe,
    output logic signed [32:0]         o_result_num,
    output logic signed [31:0]         o_result_den,
    output logic                       o_den_zero
);
    logic          s_fbusy, s_fvalid, s_qfull, s_qvalid, s_pop;
    rau_pkg::t_raw s_fraw, s_qraw;

    assign o_busy = s_fbusy;

    rau_front #(.W(OPERAND_WIDTH)) u_front (
        .i_clk, .i_rst_n, .i_go(i_start), .i_command, .i_a_num, .i_a_den,
        .i_b_num, .i_b_den, .o_busy(s_fbusy), .o_valid(s_fvalid),
        .o_raw(s_fraw), .i_take(!s_qfull)
    );

    rau_queue u_queue (
        .i_clk, .i_rst_n, .i_push(s_fvalid), .i_data(s_fraw), .o_full(s_qfull),
        .i_pop(s_pop), .o_valid(s_qvalid), .o_data(s_qraw)
    );

    rau_back u_back (
        .i_clk, .i_rst_n, .i_valid(s_qvalid), .i_raw(s_qraw), .o_pop(s_pop),
        .o_strobe, .o_num(o_result_num), .o_den(o_result_den),
        .o_den_zero
    );
endmodule

// ----- rtl/rau_checker.sv -----
// Port checker for the rational arithmetic unit, bound to the top level.
// Depends on rational_arith_unit ports only.
module rau_port_checks (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_start,
    input logic        o_busy,
    input logic        o_strobe,
    input logic [31:0] o_result_den,
    input logic        o_den_zero
);
    // Flag matches denominator
    a_dz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_den_zero == (o_result_den == '0))) else $error("den_zero");
    // Accepted beat makes front busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy) else $error("busy");
    // No strobe soon after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe) else $error("strobe after reset");
    // Strobe is a single cycle
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe) else $error("strobe width");
endmodule

bind rational_arith_unit rau_port_checks u_rau_checker (
    .i_clk, .i_rst_n, .i_start, .o_busy, .o_strobe, .o_result_den, .o_den_zero
);
